@@ sv/tpm_pkg.sv @@
// Shared types, constants and tables for the tidal / point-mass potential block.
// No dependencies; every other file imports this package.
package tpm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ANG_BITS      = 28;
  localparam int CORDIC_STEPS  = 28;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DIV_W         = 128;
  localparam int QUO_W         = 33;
  localparam int CNT_W         = 6;

  localparam logic signed [33:0] TWO_PI_A    = 34'sd1686629713;
  localparam logic signed [33:0] PI_A        = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_A   = 34'sd421657428;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam int MODE_ROT   = 0;
  localparam int MODE_FIXED = 1;
  localparam int MODE_CF    = 2;

  typedef enum logic [3:0] {
    REG_CENTER_X     = 4'd0,
    REG_CENTER_Y     = 4'd1,
    REG_CENTER_Z     = 4'd2,
    REG_GRAV_MASS    = 4'd3,
    REG_LENGTH_SCALE = 4'd4,
    REG_ORBIT_SPEED  = 4'd5,
    REG_START_ANGLE  = 4'd6,
    REG_MODE         = 4'd7
  } tpm_reg_e;

  typedef enum logic [1:0] {
    K_POINT     = 2'd0,
    K_ROT_FIXED = 2'd1,
    K_ROT_ORBIT = 2'd2
  } tpm_kind_e;

  typedef enum logic [3:0] {
    B_IDLE, B_VT, B_ADIV, B_ASH, B_AFIN, B_CSET, B_CORD, B_MUL,
    B_SQRT, B_PSET, B_NSET, B_DSET, B_DIV, B_DONE
  } tpm_state_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        sim_time;
  } tpm_in_t;

  typedef struct packed {
    logic signed [31:0] potential;
    logic               saturated;
  } tpm_out_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        grav_mass;
    logic [30:0]        length_scale;
    logic signed [31:0] orbit_speed;
    logic signed [30:0] start_angle;
    logic [2:0]         mode;
  } tpm_cfg_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic [30:0]        tm;
    tpm_kind_e          kind;
    logic               cf;
  } tpm_ent_t;

  function automatic logic signed [31:0] atan_val(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      5'd24: v = 32'sd16;
      5'd25: v = 32'sd8;
      5'd26: v = 32'sd4;
      5'd27: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/tidal_or_point_mass_potential.sv @@
// Top level of the external potential evaluator: configuration registers,
// front classifier, queue and back sequencer. Depends on tpm_pkg, tpm_front, tpm_queue and tpm_back.
//
// Positions are accepted one per cycle while the queue is not full, into a
// four-entry queue after the center offsets are formed; the back sequencer then
// evaluates one item at a time over a single shared 34x34 multiplier, a
// one-bit-per-cycle restoring divider, a 28-step CORDIC and a two-bit-per-cycle
// square root. Results wait in one output register; the queue keeps filling
// while a result is not taken.
module tidal_or_point_mass_potential
  import tpm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  tpm_in_t     in_data,
  output logic        empty,
  input  logic        pop,
  output tpm_out_t    out_data,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);
  localparam tpm_cfg_t CFG_RESET = '{32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd65536,
                                     32'sd0, 31'sd0, 3'd0};

  tpm_cfg_t cfg_r, cfg_nxt;
  tpm_ent_t f_ent, q_ent;
  logic     q_wr, q_pop, q_full, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X:     cfg_nxt.center_x     = cfg_wdata;
        REG_CENTER_Y:     cfg_nxt.center_y     = cfg_wdata;
        REG_CENTER_Z:     cfg_nxt.center_z     = cfg_wdata;
        REG_GRAV_MASS:    cfg_nxt.grav_mass    = cfg_wdata[30:0];
        REG_LENGTH_SCALE: cfg_nxt.length_scale = cfg_wdata[30:0];
        REG_ORBIT_SPEED:  cfg_nxt.orbit_speed  = cfg_wdata;
        REG_START_ANGLE:  cfg_nxt.start_angle  = cfg_wdata[30:0];
        REG_MODE:         cfg_nxt.mode         = cfg_wdata[2:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tpm_front u_front (
    .push    (push),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .full    (full),
    .q_wr    (q_wr),
    .q_ent   (f_ent)
  );

  tpm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_ent  (f_ent),
    .rd_en   (q_pop),
    .rd_ent  (q_ent),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  tpm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_ent    (q_ent),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

@@ sv/tpm_queue.sv @@
// Small FIFO between the front classifier and the back sequencer.
// Depends on tpm_pkg for the entry type and depth.
module tpm_queue
  import tpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  tpm_ent_t wr_ent,
  input  logic     rd_en,
  output tpm_ent_t rd_ent,
  output logic     q_full,
  output logic     q_empty
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  tpm_ent_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_ent  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_ent;
    end
  end

endmodule

@@ sv/tpm_front.sv @@
// Front end: accepts positions, forms saturated offsets and classifies the mode.
// Depends on tpm_pkg; feeds tpm_queue.
module tpm_front
  import tpm_pkg::*;
(
  input  logic     push,
  input  tpm_in_t  in_data,
  input  tpm_cfg_t cfg,
  input  logic     q_full,
  output logic     full,
  output logic     q_wr,
  output tpm_ent_t q_ent
);

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [31:0] r;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      r = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_ent.dx = sat_sub(in_data.pos_x, cfg.center_x);
    q_ent.dy = sat_sub(in_data.pos_y, cfg.center_y);
    q_ent.dz = sat_sub(in_data.pos_z, cfg.center_z);
    q_ent.tm = in_data.sim_time;
    q_ent.cf = cfg.mode[MODE_CF];
    if (!cfg.mode[MODE_ROT]) begin
      q_ent.kind = K_POINT;
    end else if (cfg.mode[MODE_FIXED]) begin
      q_ent.kind = K_ROT_FIXED;
    end else begin
      q_ent.kind = K_ROT_ORBIT;
    end
  end

endmodule

@@ sv/tpm_back.sv @@
// Back end: sequencer over a shared multiplier, CORDIC, square root and divider.
// Depends on tpm_pkg; drains tpm_queue and holds the result register.
module tpm_back
  import tpm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic     clk,
  input  logic     rst_n,
  input  tpm_cfg_t cfg,
  input  tpm_ent_t q_ent,
  input  logic     q_empty,
  output logic     q_pop,
  output tpm_out_t out_data,
  output logic     empty,
  input  logic     pop
);
  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam logic [CNT_W-1:0] MS_DXC = 6'd0, MS_DYS = 6'd1, MS_TQ = 6'd2,
    MS_DX2 = 6'd3, MS_DY2 = 6'd4, MS_DZ2 = 6'd5, MS_L2 = 6'd6, MS_GM0 = 6'd7,
    MS_GM1 = 6'd8, MS_D0 = 6'd9, MS_D1 = 6'd10;

  tpm_state_e state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_vld_r, out_vld_nxt;
  tpm_out_t out_data_r, out_data_nxt;

  logic signed [31:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [30:0] tm_r, tm_nxt;
  tpm_kind_e kind_r, kind_nxt;
  logic cf_r, cf_nxt;
  logic [62:0] mq_r, mq_nxt;
  logic [30:0] ar_r, ar_nxt, qm_r, qm_nxt, fr_r, fr_nxt, ang_r, ang_nxt;
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [31:0] ca_r, ca_nxt;
  logic flip_r, flip_nxt;
  logic signed [65:0] tacc_r, tacc_nxt;
  logic [63:0] t2_r, t2_nxt, sxy_r, sxy_nxt, sum_r, sum_nxt;
  logic [61:0] l2_r, l2_nxt;
  logic [65:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt;
  logic [96:0] num_r, num_nxt;
  logic [63:0] sqv_r, sqv_nxt, sqres_r, sqres_nxt, sqbit_r, sqbit_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt, den_r, den_nxt, dsh_r, dsh_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic ovf_r, ovf_nxt;

  logic [30:0] len;
  logic [31:0] vm;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [65:0] tr;
  logic signed [33:0] tq;
  logic out_free;

  assign len      = (cfg.length_scale == '0) ? 31'd1 : cfg.length_scale;
  assign vm       = cfg.orbit_speed[31] ? 32'(~cfg.orbit_speed + 32'sd1) : cfg.orbit_speed;
  assign tr       = tacc_r + 66'sd536870912;
  assign tq       = tr[63:30];
  assign prod     = ma * mb;
  assign out_free = !out_vld_r || pop;
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign empty    = !out_vld_r;
  assign out_data = out_data_r;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      B_VT: begin
        ma = $signed({2'b00, vm});
        mb = $signed({3'b000, tm_r});
      end
      B_MUL: begin
        case (cnt_r)
          MS_DXC: begin ma = 34'(dx_r); mb = cx_r; end
          MS_DYS: begin ma = 34'(dy_r); mb = cy_r; end
          MS_TQ:  begin ma = tq; mb = tq; end
          MS_DX2: begin ma = 34'(dx_r); mb = 34'(dx_r); end
          MS_DY2: begin ma = 34'(dy_r); mb = 34'(dy_r); end
          MS_DZ2: begin ma = 34'(dz_r); mb = 34'(dz_r); end
          MS_L2:  begin ma = $signed({3'b000, len}); mb = $signed({3'b000, len}); end
          MS_GM0: begin
            ma = $signed({1'b0, mag_r[32:0]});
            mb = $signed({3'b000, cfg.grav_mass});
          end
          MS_GM1: begin
            ma = $signed({1'b0, mag_r[65:33]});
            mb = $signed({3'b000, cfg.grav_mass});
          end
          MS_D0: begin ma = $signed({3'b000, l2_r[30:0]}); mb = $signed({3'b000, len}); end
          MS_D1: begin ma = $signed({3'b000, l2_r[61:31]}); mb = $signed({3'b000, len}); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_ent.kind)
            K_ROT_ORBIT: state_nxt = B_VT;
            K_ROT_FIXED: state_nxt = B_CSET;
            default:     state_nxt = B_MUL;
          endcase
        end
      end
      B_VT:   state_nxt = B_ADIV;
      B_ADIV: if (cnt_r == CNT_W'(62)) state_nxt = B_ASH;
      B_ASH:  if (cnt_r == CNT_W'(SH - 1)) state_nxt = B_AFIN;
      B_AFIN: state_nxt = B_CSET;
      B_CSET: state_nxt = B_CORD;
      B_CORD: if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = B_MUL;
      B_MUL: begin
        if (cnt_r == MS_L2 && kind_r == K_POINT) begin
          state_nxt = B_SQRT;
        end else if (cnt_r == MS_D1) begin
          state_nxt = B_NSET;
        end
      end
      B_SQRT: if (cnt_r == CNT_W'(31)) state_nxt = B_PSET;
      B_PSET: state_nxt = B_DSET;
      B_NSET: state_nxt = B_DSET;
      B_DSET: state_nxt = B_DIV;
      B_DIV:  if (cnt_r == CNT_W'(QUO_W - 1)) state_nxt = B_DONE;
      B_DONE: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    logic [31:0] rs, qd, s32;
    logic ge;
    logic signed [33:0] a, a0, xn, yn;
    logic signed [31:0] an;
    logic [4:0] ci;
    logic [65:0] pw, nw;
    logic [63:0] sqs;
    logic signed [31:0] pv;
    logic sat;
    logic [30:0] a1;

    cnt_nxt = cnt_r + 1'b1;
    out_vld_nxt = out_vld_r && !pop;
    out_data_nxt = out_data_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r; tm_nxt = tm_r;
    kind_nxt = kind_r; cf_nxt = cf_r;
    mq_nxt = mq_r; ar_nxt = ar_r; qm_nxt = qm_r; fr_nxt = fr_r; ang_nxt = ang_r;
    cx_nxt = cx_r; cy_nxt = cy_r; ca_nxt = ca_r; flip_nxt = flip_r;
    tacc_nxt = tacc_r; t2_nxt = t2_r; sxy_nxt = sxy_r; sum_nxt = sum_r; l2_nxt = l2_r;
    mag_nxt = mag_r; neg_nxt = neg_r; num_nxt = num_r;
    sqv_nxt = sqv_r; sqres_nxt = sqres_r; sqbit_nxt = sqbit_r;
    rem_nxt = rem_r; den_nxt = den_r; dsh_nxt = dsh_r; q_nxt = q_r; ovf_nxt = ovf_r;

    rs = '0; qd = '0; s32 = '0; ge = 1'b0;
    a = '0; a0 = '0; xn = '0; yn = '0; an = '0; ci = cnt_r[4:0];
    pw = '0; nw = '0; sqs = '0; pv = '0; sat = 1'b0; a1 = '0;

    case (state_r)
      B_IDLE: begin
        cnt_nxt = '0;
        if (!q_empty) begin
          dx_nxt = q_ent.dx; dy_nxt = q_ent.dy; dz_nxt = q_ent.dz;
          tm_nxt = q_ent.tm; kind_nxt = q_ent.kind; cf_nxt = q_ent.cf;
          ang_nxt = '0;
          if (q_ent.kind == K_POINT) cnt_nxt = MS_DX2;
        end
      end
      B_VT: begin
        mq_nxt = prod[62:0];
        ar_nxt = '0;
        qm_nxt = '0;
        cnt_nxt = '0;
      end
      B_ADIV: begin
        rs = {ar_r, mq_r[62]};
        ge = rs >= {1'b0, len};
        ar_nxt = ge ? 31'(rs - {1'b0, len}) : rs[30:0];
        qd = {qm_r, ge};
        qm_nxt = (qd >= TWO_PI_A[31:0]) ? 31'(qd - TWO_PI_A[31:0]) : qd[30:0];
        mq_nxt = {mq_r[61:0], 1'b0};
        fr_nxt = '0;
        if (cnt_r == CNT_W'(62)) cnt_nxt = '0;
      end
      B_ASH: begin
        rs = {ar_r, 1'b0};
        ge = rs >= {1'b0, len};
        ar_nxt = ge ? 31'(rs - {1'b0, len}) : rs[30:0];
        fr_nxt = {fr_r[29:0], ge};
        qd = {qm_r, 1'b0};
        qm_nxt = (qd >= TWO_PI_A[31:0]) ? 31'(qd - TWO_PI_A[31:0]) : qd[30:0];
      end
      B_AFIN: begin
        s32 = {1'b0, qm_r} + {1'b0, fr_r};
        a1 = (s32 >= TWO_PI_A[31:0]) ? 31'(s32 - TWO_PI_A[31:0]) : s32[30:0];
        if (cfg.orbit_speed[31] && a1 != '0) a1 = 31'(TWO_PI_A[31:0] - {1'b0, a1});
        ang_nxt = a1;
      end
      B_CSET: begin
        a0 = cfg.start_angle[30] ? 34'(cfg.start_angle) + TWO_PI_A : 34'(cfg.start_angle);
        a = $signed({3'b000, ang_r}) + a0;
        if (a >= TWO_PI_A) a = a - TWO_PI_A;
        if (a > PI_A) a = a - TWO_PI_A;
        flip_nxt = 1'b0;
        if (a > HALF_PI_A) begin
          a = a - PI_A;
          flip_nxt = 1'b1;
        end else if (a < -HALF_PI_A) begin
          a = a + PI_A;
          flip_nxt = 1'b1;
        end
        ca_nxt = a[31:0];
        cx_nxt = CORDIC_GAIN;
        cy_nxt = '0;
        cnt_nxt = '0;
      end
      B_CORD: begin
        if (!ca_r[31]) begin
          xn = cx_r - (cy_r >>> ci);
          yn = cy_r + (cx_r >>> ci);
          an = ca_r - atan_val(ci);
        end else begin
          xn = cx_r + (cy_r >>> ci);
          yn = cy_r - (cx_r >>> ci);
          an = ca_r + atan_val(ci);
        end
        ca_nxt = an;
        cx_nxt = xn;
        cy_nxt = yn;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_nxt = MS_DXC;
          if (flip_r) begin
            cx_nxt = -xn;
            cy_nxt = -yn;
          end
        end
      end
      B_MUL: begin
        case (cnt_r)
          MS_DXC: tacc_nxt = prod[65:0];
          MS_DYS: tacc_nxt = tacc_r + prod[65:0];
          MS_TQ:  t2_nxt = prod[63:0];
          MS_DX2: sxy_nxt = prod[63:0];
          MS_DY2: sxy_nxt = sxy_r + prod[63:0];
          MS_DZ2: sum_nxt = sxy_r + prod[63:0];
          MS_L2: begin
            l2_nxt = prod[61:0];
            pw = {2'b00, sum_r};
            nw = {2'b00, t2_r} + {1'b0, t2_r, 1'b0} + (cf_r ? {2'b00, sxy_r} : 66'd0);
            neg_nxt = nw > pw;
            mag_nxt = (nw > pw) ? nw - pw : pw - nw;
            sqv_nxt = sum_r + prod[63:0];
            sqres_nxt = '0;
            sqbit_nxt = 64'h4000_0000_0000_0000;
            if (kind_r == K_POINT) cnt_nxt = '0;
          end
          MS_GM0: num_nxt = {33'd0, prod[63:0]};
          MS_GM1: num_nxt = num_r + {prod[63:0], 33'd0};
          MS_D0:  den_nxt = DIV_W'(prod[63:0]);
          MS_D1:  den_nxt = den_r + DIV_W'({prod[63:0], 31'd0});
          default: tacc_nxt = tacc_r;
        endcase
      end
      B_SQRT: begin
        sqs = sqres_r + sqbit_r;
        if (sqv_r >= sqs) begin
          sqv_nxt = sqv_r - sqs;
          sqres_nxt = (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_nxt = sqres_r >> 1;
        end
        sqbit_nxt = sqbit_r >> 2;
      end
      B_PSET: begin
        rem_nxt = (DIV_W'(cfg.grav_mass) << FRAC_BITS) + DIV_W'(sqres_r >> 1);
        den_nxt = DIV_W'(sqres_r);
        neg_nxt = 1'b1;
      end
      B_NSET: begin
        rem_nxt = (DIV_W'(num_r) << (FRAC_BITS - 1)) + (den_r >> 1);
      end
      B_DSET: begin
        ovf_nxt = rem_r >= (den_r << QUO_W);
        dsh_nxt = den_r << (QUO_W - 1);
        q_nxt = '0;
        cnt_nxt = '0;
      end
      B_DIV: begin
        ge = rem_r >= dsh_r;
        if (ge) rem_nxt = rem_r - dsh_r;
        q_nxt = {q_r[QUO_W-2:0], ge};
        dsh_nxt = dsh_r >> 1;
      end
      B_DONE: begin
        if (!neg_r) begin
          sat = ovf_r || (q_r[QUO_W-1:31] != '0);
          pv = sat ? 32'sh7fff_ffff : $signed(q_r[31:0]);
        end else begin
          sat = ovf_r || q_r[QUO_W-1] || (q_r[31] && q_r[30:0] != '0);
          pv = sat ? 32'sh8000_0000 : $signed(~q_r[31:0] + 32'd1);
        end
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_data_nxt.potential = pv;
          out_data_nxt.saturated = sat;
        end
      end
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt; tm_r <= tm_nxt;
    kind_r <= kind_nxt; cf_r <= cf_nxt;
    mq_r <= mq_nxt; ar_r <= ar_nxt; qm_r <= qm_nxt; fr_r <= fr_nxt; ang_r <= ang_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; ca_r <= ca_nxt; flip_r <= flip_nxt;
    tacc_r <= tacc_nxt; t2_r <= t2_nxt; sxy_r <= sxy_nxt; sum_r <= sum_nxt;
    l2_r <= l2_nxt; mag_r <= mag_nxt; neg_r <= neg_nxt; num_r <= num_nxt;
    sqv_r <= sqv_nxt; sqres_r <= sqres_nxt; sqbit_r <= sqbit_nxt;
    rem_r <= rem_nxt; den_r <= den_nxt; dsh_r <= dsh_nxt; q_r <= q_nxt; ovf_r <= ovf_nxt;
  end

endmodule

@@ sv/tpm_chk.sv @@
// Port-level checker for the potential evaluator, bound to the top level.
// Depends on tpm_pkg for the result type.
module tpm_chk
  import tpm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input tpm_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
      (!empty && out_data.saturated) |->
      (out_data.potential == 32'sh7fff_ffff || out_data.potential == 32'sh8000_0000))
    else $error("saturated result not at a range end");

endmodule

bind tidal_or_point_mass_potential tpm_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
